@@ sv/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the barometric pressure compensation block:
// datapath widths, register map, calibration reset values and special codes.
// ----------------------------------------------------------------------------
package bpc_pkg;

    // register map
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_AC1 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AC2 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AC3 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_AC4 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_B1  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_B2  = 3'd5;

    // calibration reset values
    localparam logic signed [15:0] AC1_RST = 16'sd408;
    localparam logic signed [15:0] AC2_RST = -16'sd72;
    localparam logic signed [15:0] AC3_RST = -16'sd14383;
    localparam logic        [15:0] AC4_RST = 16'd32741;
    localparam logic signed [15:0] B1_RST  = 16'sd6190;
    localparam logic signed [15:0] B2_RST  = 16'sd4;

    // compensation constants
    localparam logic signed [18:0] B6_OFS    = 19'sd4000;
    localparam logic signed [43:0] B7_SCALE  = 44'sd50000;
    localparam logic signed [22:0] X3_OFS    = 23'sd32768;
    localparam logic        [11:0] QUAD_K    = 12'd3038;
    localparam logic signed [15:0] LIN_K     = -16'sd7357;
    localparam logic signed [42:0] CORR_OFS  = 43'sd3791;
    localparam logic        [17:0] PA_MAX    = 18'd262143;

    // truncating divide by 100: (pa >> 2) * 83887 >> 21, exact for pa < 2^18
    localparam logic        [16:0] HPA_MULT  = 17'd83887;
    localparam int unsigned        HPA_SHIFT = 21;

    // divider geometry: 43-bit dividend, 24-bit divisor, 30 quotient bits
    localparam int unsigned DVD_W     = 43;
    localparam int unsigned DSR_W     = 24;
    localparam int unsigned DIV_STEPS = 30;

    // end-to-end latency: 7 front stages, divider, 6 back stages
    localparam int unsigned LATENCY   = 7 + DIV_STEPS + 6;

    // special result codes
    localparam logic [1:0] SP_NONE = 2'd0;
    localparam logic [1:0] SP_ZERO = 2'd1;
    localparam logic [1:0] SP_MAX  = 2'd2;

    typedef struct packed {
        logic [1:0] sp;
        logic       case_a;
    } bpc_tag_t;

endpackage

@@ sv/bpc_div.sv @@
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined restoring divider, one quotient bit per stage; a side tag
// travels with each operand pair.
// ----------------------------------------------------------------------------
module bpc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [bpc_pkg::DVD_W-1:0]    in_dividend,
    input  logic [bpc_pkg::DSR_W-1:0]    in_divisor,
    input  bpc_pkg::bpc_tag_t            in_tag,
    output logic                         out_valid,
    output logic [bpc_pkg::DIV_STEPS-1:0] out_quot,
    output logic [bpc_pkg::DSR_W-1:0]    out_rem,
    output logic [bpc_pkg::DSR_W-1:0]    out_divisor,
    output bpc_pkg::bpc_tag_t            out_tag
);
    import bpc_pkg::*;

    logic                 vld_reg [DIV_STEPS];
    logic [DSR_W-1:0]     rem_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] dq_reg  [DIV_STEPS];
    logic [DSR_W-1:0]     dsr_reg [DIV_STEPS];
    bpc_tag_t             tag_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : step_gen
        logic                 vld_in;
        logic [DSR_W-1:0]     rem_in;
        logic [DIV_STEPS-1:0] dq_in;
        logic [DSR_W-1:0]     dsr_in;
        bpc_tag_t             tag_in;
        logic [DSR_W:0]       trial;
        logic [DSR_W:0]       diff;
        logic                 ge;
        logic [DSR_W-1:0]     rem_next;
        logic [DIV_STEPS-1:0] dq_next;

        if (k == 0)
        begin : first_gen
            // upper dividend bits seed the partial remainder
            assign vld_in = in_valid;
            assign rem_in = DSR_W'(in_dividend[DVD_W-1:DIV_STEPS]);
            assign dq_in  = in_dividend[DIV_STEPS-1:0];
            assign dsr_in = in_divisor;
            assign tag_in = in_tag;
        end
        else
        begin : next_gen
            assign vld_in = vld_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign dq_in  = dq_reg[k-1];
            assign dsr_in = dsr_reg[k-1];
            assign tag_in = tag_reg[k-1];
        end

        // dividend bits shift out the top while quotient bits enter the bottom
        assign trial    = {rem_in, dq_in[DIV_STEPS-1]};
        assign diff     = trial - {1'b0, dsr_in};
        assign ge       = (trial >= {1'b0, dsr_in});
        assign rem_next = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        assign dq_next  = {dq_in[DIV_STEPS-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            dq_reg[k]  <= dq_next;
            dsr_reg[k] <= dsr_in;
            tag_reg[k] <= tag_in;
        end
    end

    assign out_valid   = vld_reg[DIV_STEPS-1];
    assign out_quot    = dq_reg[DIV_STEPS-1];
    assign out_rem     = rem_reg[DIV_STEPS-1];
    assign out_divisor = dsr_reg[DIV_STEPS-1];
    assign out_tag     = tag_reg[DIV_STEPS-1];

endmodule

@@ sv/barometric_pressure_compensation.sv @@
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Turns a raw pressure reading and the temperature factor into true pressure
// in pascals and hectopascals, using six calibration words held in registers.
// ----------------------------------------------------------------------------
// One transaction is taken on every clock at which start is high and busy is
// low; busy is high only in the first cycle after reset, so a new reading can
// be issued every cycle. Each reading comes out as a one-cycle done strobe
// with pressure_pa and pressure_hpa; there is no way to hold the result back,
// so the receiver must capture it on that cycle. The latency is set by the
// 30-stage bit-per-stage divider in the middle of the datapath,
// with seven arithmetic stages ahead of it and six behind it. Results leave in
// the order readings were taken. The calibration registers are written over
// the APB port at byte addresses 0, 4, ..., 20 (ac1, ac2, ac3, ac4, b1, b2);
// write them only while no reading is in flight. The pascal output is clamped
// to 0..262143: a raw value below the offset reads as 0, and a non-positive
// divisor or an oversized quotient reads as 262143.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // command side
    input  logic                        start,
    output logic                        busy,
    input  logic [15:0]                 raw_pressure,
    input  logic signed [17:0]          temp_factor,
    // result side
    output logic                        done,
    output logic [17:0]                 pressure_pa,
    output logic [11:0]                 pressure_hpa
);
    import bpc_pkg::*;

    // ------------------------------------------------------------------
    // calibration registers
    // ------------------------------------------------------------------
    logic signed [15:0] ac1_reg;
    logic signed [15:0] ac2_reg;
    logic signed [15:0] ac3_reg;
    logic        [15:0] ac4_reg;
    logic signed [15:0] b1_reg;
    logic signed [15:0] b2_reg;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_reg <= AC1_RST;
            ac2_reg <= AC2_RST;
            ac3_reg <= AC3_RST;
            ac4_reg <= AC4_RST;
            b1_reg  <= B1_RST;
            b2_reg  <= B2_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_AC1: ac1_reg <= pwdata[15:0];
                REG_AC2: ac2_reg <= pwdata[15:0];
                REG_AC3: ac3_reg <= pwdata[15:0];
                REG_AC4: ac4_reg <= pwdata[15:0];
                REG_B1:  b1_reg  <= pwdata[15:0];
                REG_B2:  b2_reg  <= pwdata[15:0];
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    // read back, signed words sign-extended
    always_comb
    begin
        unique case (reg_idx)
            REG_AC1: prdata = 32'(ac1_reg);
            REG_AC2: prdata = 32'(ac2_reg);
            REG_AC3: prdata = 32'(ac3_reg);
            REG_AC4: prdata = {16'd0, ac4_reg};
            REG_B1:  prdata = 32'(b1_reg);
            REG_B2:  prdata = 32'(b2_reg);
            default: prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // command handshake: busy only right after reset
    // ------------------------------------------------------------------
    logic busy_reg;
    logic in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy    = busy_reg;
    assign in_fire = start & ~busy_reg;

    // ------------------------------------------------------------------
    // front pipeline: valid bits
    // ------------------------------------------------------------------
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic s5_vld_reg, s6_vld_reg, s7_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_fire;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
        end
    end

    // stage 1: b6 = b5 - 4000
    logic [15:0]        s1_up_reg;
    logic signed [18:0] s1_b6_reg;
    logic signed [18:0] s1_b6_next;

    assign s1_b6_next = 19'(temp_factor) - B6_OFS;

    always_ff @(posedge clk)
    begin
        s1_up_reg <= raw_pressure;
        s1_b6_reg <= s1_b6_next;
    end

    // stage 2: b6 squared and the two linear b6 products
    logic [15:0]        s2_up_reg;
    logic [34:0]        s2_b6sq_reg;
    logic signed [34:0] s2_ac2b6_reg;
    logic signed [34:0] s2_ac3b6_reg;
    logic signed [37:0] b6sq_full;
    logic signed [34:0] s2_ac2b6_next;
    logic signed [34:0] s2_ac3b6_next;

    assign b6sq_full     = s1_b6_reg * s1_b6_reg;
    assign s2_ac2b6_next = ac2_reg * s1_b6_reg;
    assign s2_ac3b6_next = ac3_reg * s1_b6_reg;

    always_ff @(posedge clk)
    begin
        s2_up_reg    <= s1_up_reg;
        s2_b6sq_reg  <= b6sq_full[34:0];   // square is never negative
        s2_ac2b6_reg <= s2_ac2b6_next;
        s2_ac3b6_reg <= s2_ac3b6_next;
    end

    // stage 3: quadratic terms b2*sq and b1*sq, with sq = b6^2 >> 12
    logic [15:0]        s3_up_reg;
    logic signed [38:0] s3_b2sq_reg;
    logic signed [38:0] s3_b1sq_reg;
    logic signed [23:0] s3_x2_reg;
    logic signed [21:0] s3_x1c_reg;
    logic signed [23:0] sq_s;
    logic signed [38:0] s3_b2sq_next;
    logic signed [38:0] s3_b1sq_next;

    assign sq_s         = $signed({1'b0, s2_b6sq_reg[34:12]});
    assign s3_b2sq_next = b2_reg * sq_s;
    assign s3_b1sq_next = b1_reg * sq_s;

    always_ff @(posedge clk)
    begin
        s3_up_reg   <= s2_up_reg;
        s3_b2sq_reg <= s3_b2sq_next;
        s3_b1sq_reg <= s3_b1sq_next;
        s3_x2_reg   <= s2_ac2b6_reg[34:11];  // ac2*b6 >> 11
        s3_x1c_reg  <= s2_ac3b6_reg[34:13];  // ac3*b6 >> 13
    end

    // stage 4: b3 and x3 sums with rounding offset, then >> 2
    logic [15:0]        s4_up_reg;
    logic signed [26:0] s4_b3_reg;
    logic signed [21:0] s4_x3_reg;
    logic signed [27:0] x1_s;
    logic signed [22:0] x2c_s;
    logic signed [28:0] ac1x4;
    logic signed [28:0] b3_sum;
    logic signed [23:0] x3_sum;

    assign x1_s   = s3_b2sq_reg[38:11];
    assign x2c_s  = s3_b1sq_reg[38:16];
    assign ac1x4  = $signed({{11{ac1_reg[15]}}, ac1_reg, 2'b00});
    assign b3_sum = ac1x4 + 29'(x1_s) + 29'(s3_x2_reg) + 29'sd2;
    assign x3_sum = 24'(s3_x1c_reg) + 24'(x2c_s) + 24'sd2;

    always_ff @(posedge clk)
    begin
        s4_up_reg <= s3_up_reg;
        s4_b3_reg <= b3_sum[28:2];
        s4_x3_reg <= x3_sum[23:2];
    end

    // stage 5: up - b3 and x3 + 32768
    logic signed [27:0] s5_diff_reg;
    logic signed [22:0] s5_x3o_reg;
    logic signed [27:0] s5_diff_next;
    logic signed [22:0] s5_x3o_next;

    assign s5_diff_next = $signed({12'd0, s4_up_reg}) - 28'(s4_b3_reg);
    assign s5_x3o_next  = 23'(s4_x3_reg) + X3_OFS;

    always_ff @(posedge clk)
    begin
        s5_diff_reg <= s5_diff_next;
        s5_x3o_reg  <= s5_x3o_next;
    end

    // stage 6: b7 = (up - b3) * 50000 and the scaled b4 product
    logic signed [43:0] s6_b7_reg;
    logic signed [39:0] s6_b4f_reg;
    logic signed [43:0] s6_b7_next;
    logic signed [39:0] s6_b4f_next;

    assign s6_b7_next  = s5_diff_reg * B7_SCALE;
    assign s6_b4f_next = $signed({1'b0, ac4_reg}) * s5_x3o_reg;

    always_ff @(posedge clk)
    begin
        s6_b7_reg  <= s6_b7_next;
        s6_b4f_reg <= s6_b4f_next;
    end

    // stage 7: special cases and divider operands
    // quotient q = b7 / b4 with remainder r; the small-b7 form floor(2*b7/b4)
    // is recovered after the divider as 2q plus one when 2r >= b4
    logic [DVD_W-1:0]   s7_dvd_reg;
    logic [DSR_W-1:0]   s7_dsr_reg;
    bpc_tag_t           s7_tag_reg;
    logic signed [24:0] b4_s;
    logic               b4_bad;
    logic               q_ovf;
    bpc_tag_t           s7_tag_next;

    assign b4_s   = s6_b4f_reg[39:15];
    assign b4_bad = b4_s[24] | (b4_s == 25'sd0);
    // a quotient of 2^30 or more doubles past the 31-bit limit
    assign q_ovf  = (DSR_W'(s6_b7_reg[DVD_W-1:DIV_STEPS]) >= b4_s[DSR_W-1:0]);

    always_comb
    begin
        s7_tag_next.case_a = (s6_b7_reg[DVD_W-1:31] == '0);
        if (s6_b7_reg[43])
        begin
            s7_tag_next.sp = SP_ZERO;
        end
        else if (b4_bad | q_ovf)
        begin
            s7_tag_next.sp = SP_MAX;
        end
        else
        begin
            s7_tag_next.sp = SP_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        s7_dvd_reg <= s6_b7_reg[DVD_W-1:0];
        s7_dsr_reg <= b4_s[DSR_W-1:0];
        s7_tag_reg <= s7_tag_next;
    end

    // ------------------------------------------------------------------
    // divider
    // ------------------------------------------------------------------
    logic                 div_valid;
    logic [DIV_STEPS-1:0] div_quot;
    logic [DSR_W-1:0]     div_rem;
    logic [DSR_W-1:0]     div_dsr;
    bpc_tag_t             div_tag;

    bpc_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s7_vld_reg),
        .in_dividend (s7_dvd_reg),
        .in_divisor  (s7_dsr_reg),
        .in_tag      (s7_tag_reg),
        .out_valid   (div_valid),
        .out_quot    (div_quot),
        .out_rem     (div_rem),
        .out_divisor (div_dsr),
        .out_tag     (div_tag)
    );

    // ------------------------------------------------------------------
    // back pipeline: valid bits
    // ------------------------------------------------------------------
    logic q1_vld_reg, q2_vld_reg, q3_vld_reg, q4_vld_reg, q5_vld_reg;
    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_vld_reg <= 1'b0;
            q2_vld_reg <= 1'b0;
            q3_vld_reg <= 1'b0;
            q4_vld_reg <= 1'b0;
            q5_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            q1_vld_reg <= div_valid;
            q2_vld_reg <= q1_vld_reg;
            q3_vld_reg <= q2_vld_reg;
            q4_vld_reg <= q3_vld_reg;
            q5_vld_reg <= q4_vld_reg;
            done_reg   <= q5_vld_reg;
        end
    end

    // back stage 1: p = 2q + rounding bit for the small-b7 form
    logic [30:0] q1_p_reg;
    logic [1:0]  q1_sp_reg;
    logic        p_bump;

    assign p_bump = div_tag.case_a & ({div_rem, 1'b0} >= {1'b0, div_dsr});

    always_ff @(posedge clk)
    begin
        q1_p_reg  <= {div_quot, p_bump};
        q1_sp_reg <= div_tag.sp;
    end

    // back stage 2: (p >> 8)^2 and -7357 * p
    logic [30:0]        q2_p_reg;
    logic [1:0]         q2_sp_reg;
    logic [45:0]        q2_asq_reg;
    logic signed [44:0] q2_lin_reg;
    logic [45:0]        q2_asq_next;
    logic signed [44:0] q2_lin_next;

    assign q2_asq_next = q1_p_reg[30:8] * q1_p_reg[30:8];
    assign q2_lin_next = LIN_K * $signed({1'b0, q1_p_reg});

    always_ff @(posedge clk)
    begin
        q2_p_reg   <= q1_p_reg;
        q2_sp_reg  <= q1_sp_reg;
        q2_asq_reg <= q2_asq_next;
        q2_lin_reg <= q2_lin_next;
    end

    // back stage 3: quadratic term times 3038
    logic [30:0]        q3_p_reg;
    logic [1:0]         q3_sp_reg;
    logic [57:0]        q3_quad_reg;
    logic signed [28:0] q3_lin_reg;
    logic [57:0]        q3_quad_next;

    assign q3_quad_next = q2_asq_reg * QUAD_K;

    always_ff @(posedge clk)
    begin
        q3_p_reg    <= q2_p_reg;
        q3_sp_reg   <= q2_sp_reg;
        q3_quad_reg <= q3_quad_next;
        q3_lin_reg  <= q2_lin_reg[44:16];   // -7357*p >> 16
    end

    // back stage 4: x1 + x2 + 3791
    logic [30:0]        q4_p_reg;
    logic [1:0]         q4_sp_reg;
    logic signed [42:0] q4_t_reg;
    logic signed [42:0] q4_t_next;

    assign q4_t_next = $signed({1'b0, q3_quad_reg[57:16]}) + 43'(q3_lin_reg) + CORR_OFS;

    always_ff @(posedge clk)
    begin
        q4_p_reg  <= q3_p_reg;
        q4_sp_reg <= q3_sp_reg;
        q4_t_reg  <= q4_t_next;
    end

    // back stage 5: corrected pressure and clamp
    logic [17:0]        q5_pa_reg;
    logic signed [38:0] t_sh;
    logic signed [39:0] p_corr;
    logic [17:0]        q5_pa_next;

    assign t_sh   = q4_t_reg[42:4];
    assign p_corr = $signed({9'd0, q4_p_reg}) + 40'(t_sh);

    always_comb
    begin
        case (q4_sp_reg)
            SP_ZERO: q5_pa_next = '0;
            SP_MAX:  q5_pa_next = PA_MAX;
            default:
            begin
                if (p_corr[39])
                begin
                    q5_pa_next = '0;
                end
                else if (p_corr > 40'sd262143)
                begin
                    q5_pa_next = PA_MAX;
                end
                else
                begin
                    q5_pa_next = p_corr[17:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        q5_pa_reg <= q5_pa_next;
    end

    // back stage 6: output registers, hectopascals by reciprocal multiply
    logic [17:0] pressure_pa_reg;
    logic [11:0] pressure_hpa_reg;
    logic [32:0] hpa_prod;

    assign hpa_prod = q5_pa_reg[17:2] * HPA_MULT;

    always_ff @(posedge clk)
    begin
        pressure_pa_reg  <= q5_pa_reg;
        pressure_hpa_reg <= hpa_prod[HPA_SHIFT +: 12];
    end

    assign done         = done_reg;
    assign pressure_pa  = pressure_pa_reg;
    assign pressure_hpa = pressure_hpa_reg;

`ifndef SYNTHESIS
    // every accepted transaction yields a result a fixed time later
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> ##LATENCY done)
        else $error("accepted transaction produced no result strobe");

    // every result strobe traces back to an accepted transaction
    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_fire, LATENCY))
        else $error("result strobe without an accepted transaction");

    // hectopascal output is the truncated pascal value over 100
    a_hpa: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pressure_hpa == 12'(pressure_pa / 18'd100)))
        else $error("hectopascal output disagrees with pascal output");

    // with no special case flagged the divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid && (div_tag.sp == SP_NONE)) |-> (div_rem < div_dsr))
        else $error("divider remainder not below divisor");
`endif

endmodule
